>>> rtl/free_channel_id_search_defines.svh
// Assertion macros for the free channel id search block.
`ifndef FREE_CHANNEL_ID_SEARCH_DEFINES_SVH
`define FREE_CHANNEL_ID_SEARCH_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define FCIS_ASSERT_CLK(clk, rst_n, lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define FCIS_ASSERT(lbl, prop, msg) \
  `FCIS_ASSERT_CLK(clk_i, rst_ni, lbl, prop, msg)

`else

`define FCIS_ASSERT_CLK(clk, rst_n, lbl, prop, msg)

`define FCIS_ASSERT(lbl, prop, msg)

`endif

`endif

>>> rtl/fcis_pkg.sv
package fcis_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF      = 64;
  localparam int unsigned FIRST_FREE_CHANNEL_DEF = 32;
  localparam int unsigned MAX_PATH_BITS_DEF      = 12;
  localparam int unsigned MAX_CHANNEL_BITS_DEF   = 16;

  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned PATH_W      = 12;
  localparam int unsigned CHAN_W      = 16;
  // cursor and limit widths cover id spaces up to 16 bits
  localparam int unsigned CUR_W       = 16;
  localparam int unsigned LIM_W       = 17;
  localparam int unsigned BITS_W      = 5;
  localparam int unsigned PBITS_W     = 4;
  localparam int unsigned CFG_DW      = 5;
  localparam int unsigned CFG_IW      = 1;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [PBITS_W-1:0] PATH_BITS_RST = 4'd8;
  localparam logic [BITS_W-1:0]  CHAN_BITS_RST = 5'd16;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_FIND  = 1'b1
  } op_e;

  typedef enum logic [CFG_IW-1:0] {
    REG_PATH_BITS = 1'b0,
    REG_CHAN_BITS = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    op_e               opcode;
    logic [SLOT_W-1:0] slot;
    logic              entry_valid;
    logic [PATH_W-1:0] path_id;
    logic [CHAN_W-1:0] channel_id;
    logic              path_any;
    logic              channel_any;
    logic              tx_active;
    logic              rx_active;
  } item_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic              valid;
    logic [PATH_W-1:0] path;
    logic [CHAN_W-1:0] chan;
    logic              tx;
    logic              rx;
  } wr_t;

  typedef struct packed {
    logic [CUR_W-1:0] p;
    logic [CUR_W-1:0] c;
    logic             tx;
    logic             rx;
  } cand_t;

endpackage

>>> rtl/fcis_table.sv
module fcis_table #(
  parameter int unsigned TABLE_ENTRIES = fcis_pkg::TABLE_ENTRIES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fcis_pkg::wr_t   wr_i,
  input  fcis_pkg::cand_t cand_i,
  output logic            busy_o
);

  logic [TABLE_ENTRIES-1:0]       valid_q;
  logic [fcis_pkg::PATH_W-1:0]    path_q [TABLE_ENTRIES];
  logic [fcis_pkg::CHAN_W-1:0]    chan_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]       tx_q;
  logic [TABLE_ENTRIES-1:0]       rx_q;
  logic [TABLE_ENTRIES-1:0]       we;
  logic [TABLE_ENTRIES-1:0]       hit_d;
  logic [TABLE_ENTRIES-1:0]       hit_q;

  // every row compares against the candidate at once
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      we[i]    = wr_i.en && (32'(wr_i.slot) == 32'(i));
      hit_d[i] = valid_q[i]
               && (fcis_pkg::CUR_W'(path_q[i]) == cand_i.p)
               && (fcis_pkg::CUR_W'(chan_q[i]) == cand_i.c)
               && ((tx_q[i] && cand_i.tx) || (rx_q[i] && cand_i.rx));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (we[i]) begin
          valid_q[i] <= wr_i.valid;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (we[i]) begin
        path_q[i] <= wr_i.path;
        chan_q[i] <= wr_i.chan;
        tx_q[i]   <= wr_i.tx;
        rx_q[i]   <= wr_i.rx;
      end
    end
    hit_q <= hit_d;
  end

  assign busy_o = |hit_q;

endmodule

>>> rtl/fcis_seq.sv
`include "free_channel_id_search_defines.svh"

module fcis_seq #(
  parameter int unsigned FIRST_FREE_CHANNEL = fcis_pkg::FIRST_FREE_CHANNEL_DEF,
  parameter int unsigned MAX_PATH_BITS      = fcis_pkg::MAX_PATH_BITS_DEF,
  parameter int unsigned MAX_CHANNEL_BITS   = fcis_pkg::MAX_CHANNEL_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fcis_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [fcis_pkg::CFG_DW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  fcis_pkg::item_t             item_i,
  output fcis_pkg::cand_t             cand_o,
  input  logic                        busy_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        out_status_o,
  output logic [fcis_pkg::PATH_W-1:0] out_path_o,
  output logic [fcis_pkg::CHAN_W-1:0] out_chan_o
);

  localparam int unsigned CW = fcis_pkg::CUR_W;
  localparam int unsigned LW = fcis_pkg::LIM_W;
  localparam int unsigned BW = fcis_pkg::BITS_W;
  localparam logic [CW-1:0] FFC = CW'(FIRST_FREE_CHANNEL);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_EVAL = 3'b100
  } state_e;

  state_e                         state_q, state_d;
  fcis_pkg::cand_t                cand_q, cand_d;
  logic [CW-1:0]                  start_p_q, start_p_d;
  logic [CW-1:0]                  start_c_q, start_c_d;
  logic                           pany_q, pany_d;
  logic                           cany_q, cany_d;
  logic                           chk_q, chk_d;
  logic [CW-1:0]                  cur_p_q, cur_p_d;
  logic [CW-1:0]                  cur_c_q, cur_c_d;
  logic                           out_valid_q, out_valid_d;
  logic                           out_status_q, out_status_d;
  logic [fcis_pkg::PATH_W-1:0]    out_p_q, out_p_d;
  logic [fcis_pkg::CHAN_W-1:0]    out_c_q, out_c_d;
  logic [fcis_pkg::PBITS_W-1:0]   path_bits_q;
  logic [BW-1:0]                  chan_bits_q;

  logic [BW-1:0] pb, cb;
  logic [LW-1:0] plim, clim;
  logic [CW-1:0] p0, c0, p_next, c_next;
  logic [LW-1:0] p_inc, c_inc;
  logic          p_step, wrap, done, out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_bits_q <= fcis_pkg::PATH_BITS_RST;
      chan_bits_q <= fcis_pkg::CHAN_BITS_RST;
    end else if (cfg_we_i) begin
      unique case (fcis_pkg::cfg_reg_e'(cfg_idx_i))
        fcis_pkg::REG_PATH_BITS: path_bits_q <= cfg_wdata_i[fcis_pkg::PBITS_W-1:0];
        fcis_pkg::REG_CHAN_BITS: chan_bits_q <= cfg_wdata_i[BW-1:0];
      endcase
    end
  end

  always_comb begin
    pb   = ({1'b0, path_bits_q} > BW'(MAX_PATH_BITS)) ? BW'(MAX_PATH_BITS)
                                                      : {1'b0, path_bits_q};
    cb   = (chan_bits_q > BW'(MAX_CHANNEL_BITS)) ? BW'(MAX_CHANNEL_BITS) : chan_bits_q;
    plim = LW'(1) << pb;
    clim = LW'(1) << cb;

    // first candidate
    if (!item_i.path_any) begin
      p0 = CW'(item_i.path_id);
    end else if (LW'(cur_p_q) >= plim) begin
      p0 = '0;
    end else begin
      p0 = cur_p_q;
    end
    if (!item_i.channel_any) begin
      c0 = CW'(item_i.channel_id);
    end else if ((cur_c_q < FFC) || (LW'(cur_c_q) >= clim)) begin
      c0 = FFC;
    end else begin
      c0 = cur_c_q;
    end

    // candidate step
    c_inc  = LW'(cand_q.c) + LW'(1);
    if (cany_q) begin
      c_next = (c_inc >= clim) ? FFC : c_inc[CW-1:0];
    end else begin
      c_next = cand_q.c;
    end
    p_step = pany_q && ((c_next == FFC) || !cany_q);
    p_inc  = LW'(cand_q.p) + LW'(1);
    if (p_step) begin
      p_next = (p_inc >= plim) ? '0 : p_inc[CW-1:0];
    end else begin
      p_next = cand_q.p;
    end
    wrap     = (p_next == start_p_q) && (c_next == start_c_q);
    done     = chk_q || !busy_i || wrap;
    out_free = !out_valid_q || out_ready_i;
  end

  always_comb begin
    state_d      = state_q;
    cand_d       = cand_q;
    start_p_d    = start_p_q;
    start_c_d    = start_c_q;
    pany_d       = pany_q;
    cany_d       = cany_q;
    chk_d        = chk_q;
    cur_p_d      = cur_p_q;
    cur_c_d      = cur_c_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_p_d      = out_p_q;
    out_c_d      = out_c_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && (item_i.opcode == fcis_pkg::OP_FIND)) begin
          cand_d.p  = p0;
          cand_d.c  = c0;
          cand_d.tx = item_i.tx_active;
          cand_d.rx = item_i.rx_active;
          start_p_d = p0;
          start_c_d = c0;
          pany_d    = item_i.path_any;
          cany_d    = item_i.channel_any;
          chk_d     = !item_i.path_any && !item_i.channel_any;
          state_d   = S_CMP;
        end
      end
      S_CMP: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (!done) begin
          cand_d.p = p_next;
          cand_d.c = c_next;
          state_d  = S_CMP;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (chk_q) begin
            out_status_d = busy_i;
            out_p_d      = cand_q.p[fcis_pkg::PATH_W-1:0];
            out_c_d      = cand_q.c;
          end else if (!busy_i) begin
            out_status_d = 1'b0;
            out_p_d      = cand_q.p[fcis_pkg::PATH_W-1:0];
            out_c_d      = cand_q.c;
            cur_p_d      = cand_q.p;
            cur_c_d      = cand_q.c;
          end else begin
            // exhausted: back at the starting pair
            out_status_d = 1'b1;
            out_p_d      = p_next[fcis_pkg::PATH_W-1:0];
            out_c_d      = c_next;
            cur_p_d      = p_next;
            cur_c_d      = c_next;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_p_q     <= '0;
      cur_c_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_p_q     <= cur_p_d;
      cur_c_q     <= cur_c_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q       <= cand_d;
    start_p_q    <= start_p_d;
    start_c_q    <= start_c_d;
    pany_q       <= pany_d;
    cany_q       <= cany_d;
    chk_q        <= chk_d;
    out_status_q <= out_status_d;
    out_p_q      <= out_p_d;
    out_c_q      <= out_c_d;
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign cand_o       = cand_q;
  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_path_o   = out_p_q;
  assign out_chan_o   = out_c_q;

  `FCIS_ASSERT(a_find_starts_scan,
    (in_valid_i && in_ready_o && (item_i.opcode == fcis_pkg::OP_FIND)) |=> (state_q == S_CMP),
    "find transfer did not start a compare")
  `FCIS_ASSERT(a_cmp_then_eval, (state_q == S_CMP) |=> (state_q == S_EVAL),
    "compare not followed by evaluate")
  `FCIS_ASSERT(a_check_keeps_cursors,
    (state_q == S_EVAL && chk_q) |=> ($stable(cur_p_q) && $stable(cur_c_q)),
    "collision check moved the cursors")
  `FCIS_ASSERT(a_free_pair_at_cursor,
    (state_q == S_EVAL && !chk_q && !busy_i && out_free) |=> (!out_status_q && out_c_q == cur_c_q),
    "free pair result does not match the cursor")

endmodule

>>> rtl/free_channel_id_search.sv
// Free channel id search. Holds a table of open connections (path id, channel
// id, transmit/receive use) and answers find requests with a free path/channel
// pair or an in-use status. A write transfer updates one table slot and produces
// no result. A find transfer with both ids fixed is a collision check; otherwise
// candidates are scanned from the kept cursors, each candidate being compared
// against all table rows in parallel and then evaluated to decide and step. The
// number of candidates tried is at most the number of busy pairs on the scan
// route plus one, so at most TABLE_ENTRIES + 1 when the id space exceeds the
// table. A finished result sits in an output register; the next item is taken
// while it waits. Register 0 is path_id_bits, register 1 is channel_id_bits;
// write them only while idle.
module free_channel_id_search #(
  parameter int unsigned TABLE_ENTRIES      = fcis_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned FIRST_FREE_CHANNEL = fcis_pkg::FIRST_FREE_CHANNEL_DEF,
  parameter int unsigned MAX_PATH_BITS      = fcis_pkg::MAX_PATH_BITS_DEF,
  parameter int unsigned MAX_CHANNEL_BITS   = fcis_pkg::MAX_CHANNEL_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fcis_pkg::CFG_IW-1:0]      cfg_idx_i,
  input  logic [fcis_pkg::CFG_DW-1:0]      cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // slot, entry_valid, path_id, channel_id, path_any, channel_any,
  // tx_active, rx_active
  input  logic [fcis_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // found_path, found_channel
  output logic [fcis_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // status
  output logic                             m_axis_tuser
);

  fcis_pkg::item_t             item;
  fcis_pkg::wr_t               wr;
  fcis_pkg::cand_t             cand;
  logic                        busy;
  logic                        out_status;
  logic [fcis_pkg::PATH_W-1:0] out_path;
  logic [fcis_pkg::CHAN_W-1:0] out_chan;

  always_comb begin
    item.opcode      = fcis_pkg::op_e'(s_axis_tuser);
    item.slot        = s_axis_tdata[5:0];
    item.entry_valid = s_axis_tdata[6];
    item.path_id     = s_axis_tdata[18:7];
    item.channel_id  = s_axis_tdata[34:19];
    item.path_any    = s_axis_tdata[35];
    item.channel_any = s_axis_tdata[36];
    item.tx_active   = s_axis_tdata[37];
    item.rx_active   = s_axis_tdata[38];

    wr.en    = s_axis_tvalid && s_axis_tready && (item.opcode == fcis_pkg::OP_WRITE);
    wr.slot  = item.slot;
    wr.valid = item.entry_valid;
    wr.path  = item.path_id;
    wr.chan  = item.channel_id;
    wr.tx    = item.tx_active;
    wr.rx    = item.rx_active;
  end

  fcis_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .cand_i (cand),
    .busy_o (busy)
  );

  fcis_seq #(
    .FIRST_FREE_CHANNEL (FIRST_FREE_CHANNEL),
    .MAX_PATH_BITS      (MAX_PATH_BITS),
    .MAX_CHANNEL_BITS   (MAX_CHANNEL_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .item_i       (item),
    .cand_o       (cand),
    .busy_i       (busy),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_path_o   (out_path),
    .out_chan_o   (out_chan)
  );

  assign m_axis_tdata = {4'b0, out_chan, out_path};
  assign m_axis_tuser = out_status;

endmodule

>>> verif/free_channel_id_search_test.sv
`timescale 1ns / 100ps

module free_channel_id_search_test;
  import fcis_pkg::*;

  localparam int unsigned SCAN_TAIL = 200;
  localparam int unsigned NUM_PHASES = 12;
  localparam int unsigned ITEMS_PER_PHASE = 154;

  typedef struct packed {
    logic              valid;
    logic [PATH_W-1:0] path;
    logic [CHAN_W-1:0] chan;
    logic              tx;
    logic              rx;
  } conn_entry_t;

  typedef struct {
    logic              status;
    logic [PATH_W-1:0] path;
    logic [CHAN_W-1:0] chan;
  } grant_t;

  class conn_search_board;
    conn_entry_t        conn_tab[TABLE_ENTRIES_DEF];
    logic [PATH_W-1:0]  path_cur;
    logic [CHAN_W-1:0]  chan_cur;
    logic [PBITS_W-1:0] path_bits;
    logic [BITS_W-1:0]  chan_bits;
    grant_t             expected_grants[$];
    int unsigned        errors;

    function new();
      foreach (conn_tab[i]) conn_tab[i] = '0;
      path_cur  = '0;
      chan_cur  = '0;
      path_bits = PATH_BITS_RST;
      chan_bits = CHAN_BITS_RST;
      errors    = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DW-1:0] val);
      if (idx == REG_PATH_BITS) begin
        path_bits = val[PBITS_W-1:0];
      end else begin
        chan_bits = val;
      end
    endfunction

    function bit pair_taken(int unsigned p, int unsigned c, logic tx, logic rx);
      foreach (conn_tab[i]) begin
        if (conn_tab[i].valid && conn_tab[i].path == p && conn_tab[i].chan == c &&
            ((conn_tab[i].tx && tx) || (conn_tab[i].rx && rx))) return 1'b1;
      end
      return 1'b0;
    endfunction

    function grant_t predict_grant(item_t it);
      grant_t g;
      int unsigned pb, cb, plim, clim, p, c, sp, sc;
      g.status = 1'b1;
      if (!it.path_any && !it.channel_any) begin
        g.status = pair_taken(it.path_id, it.channel_id, it.tx_active, it.rx_active);
        g.path   = it.path_id;
        g.chan   = it.channel_id;
        return g;
      end
      pb   = (path_bits > MAX_PATH_BITS_DEF) ? MAX_PATH_BITS_DEF : path_bits;
      cb   = (chan_bits > MAX_CHANNEL_BITS_DEF) ? MAX_CHANNEL_BITS_DEF : chan_bits;
      plim = 1 << pb;
      clim = 1 << cb;
      p = path_cur;
      c = chan_cur;
      if (!it.path_any) p = it.path_id;
      else if (p >= plim) p = 0;
      if (!it.channel_any) c = it.channel_id;
      else if (c < FIRST_FREE_CHANNEL_DEF || c >= clim) c = FIRST_FREE_CHANNEL_DEF;
      sp = p;
      sc = c;
      do begin
        if (!pair_taken(p, c, it.tx_active, it.rx_active)) begin
          g.status = 1'b0;
          break;
        end
        if (it.channel_any) begin
          c++;
          if (c >= clim) c = FIRST_FREE_CHANNEL_DEF;
        end
        if ((c == FIRST_FREE_CHANNEL_DEF || !it.channel_any) && it.path_any) begin
          p++;
          if (p >= plim) p = 0;
        end
      end while (p != sp || c != sc);
      path_cur = PATH_W'(p);
      chan_cur = CHAN_W'(c);
      g.path   = PATH_W'(p);
      g.chan   = CHAN_W'(c);
      return g;
    endfunction

    function void note_transfer(item_t it);
      if (it.opcode == OP_WRITE) begin
        if (it.slot < TABLE_ENTRIES_DEF) begin
          conn_tab[it.slot] = '{it.entry_valid, it.path_id, it.channel_id,
                                it.tx_active, it.rx_active};
        end
      end else begin
        expected_grants.push_back(predict_grant(it));
      end
    endfunction

    function void check_transfer(logic status, logic [PATH_W-1:0] path,
                                 logic [CHAN_W-1:0] chan);
      grant_t g;
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected result status %0d path %0d channel %0d",
                 $time, status, path, chan);
        errors++;
        return;
      end
      g = expected_grants.pop_front();
      if (status !== g.status) begin
        $display("%0t: status expected %0d actual %0d", $time, g.status, status);
        errors++;
      end
      if (path !== g.path) begin
        $display("%0t: found_path expected %0d actual %0d", $time, g.path, path);
        errors++;
      end
      if (chan !== g.chan) begin
        $display("%0t: found_channel expected %0d actual %0d", $time, g.chan, chan);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_grants.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IW-1:0]      cfg_idx_i = '0;
  logic [CFG_DW-1:0]      cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  conn_search_board board;
  bit src_quiet = 1'b0;
  bit sink_quiet = 1'b0;

  int unsigned phase_pbits[NUM_PHASES] = '{8, 0, 1, 0, 2, 3, 12, 15, 13, 4, 1, 0};
  int unsigned phase_cbits[NUM_PHASES] = '{16, 0, 5, 6, 6, 7, 16, 31, 17, 6, 8, 16};

  free_channel_id_search i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic item_t make_write(int unsigned slot, bit valid, int unsigned p,
                                       int unsigned c, bit tx, bit rx);
    item_t it;
    it = '0;
    it.opcode      = OP_WRITE;
    it.slot        = SLOT_W'(slot);
    it.entry_valid = valid;
    it.path_id     = PATH_W'(p);
    it.channel_id  = CHAN_W'(c);
    it.tx_active   = tx;
    it.rx_active   = rx;
    return it;
  endfunction

  function automatic item_t make_find(bit pany, bit cany, int unsigned p, int unsigned c,
                                      bit tx, bit rx);
    item_t it;
    it = '0;
    it.opcode      = OP_FIND;
    it.path_any    = pany;
    it.channel_any = cany;
    it.path_id     = PATH_W'(p);
    it.channel_id  = CHAN_W'(c);
    it.tx_active   = tx;
    it.rx_active   = rx;
    return it;
  endfunction

  // ids mostly from a small pool so that entries collide with the scan route
  function automatic logic [PATH_W-1:0] pick_path(int unsigned plim);
    int unsigned r, n;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      n = (plim < 4) ? plim : 4;
      return PATH_W'($urandom_range(0, n - 1));
    end
    if (r < 70) begin
      n = (plim < 2) ? plim : 2;
      return PATH_W'(plim - 1 - $urandom_range(0, n - 1));
    end
    return PATH_W'($urandom);
  endfunction

  function automatic logic [CHAN_W-1:0] pick_chan(int unsigned clim);
    int unsigned r, hi;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      if (clim <= FIRST_FREE_CHANNEL_DEF) return CHAN_W'(FIRST_FREE_CHANNEL_DEF);
      hi = (clim < FIRST_FREE_CHANNEL_DEF + 12) ? clim : FIRST_FREE_CHANNEL_DEF + 12;
      return CHAN_W'($urandom_range(FIRST_FREE_CHANNEL_DEF, hi - 1));
    end
    if (r < 62) return CHAN_W'($urandom_range(0, FIRST_FREE_CHANNEL_DEF + 8));
    if (r < 75) begin
      if (clim <= FIRST_FREE_CHANNEL_DEF) return CHAN_W'(FIRST_FREE_CHANNEL_DEF);
      return CHAN_W'(clim - 1 - $urandom_range(0, 2));
    end
    return CHAN_W'($urandom);
  endfunction

  function automatic item_t random_item(int unsigned plim, int unsigned clim);
    item_t it;
    it.opcode      = ($urandom_range(0, 99) < 40) ? OP_WRITE : OP_FIND;
    it.slot        = SLOT_W'($urandom);
    it.entry_valid = ($urandom_range(0, 99) < 85);
    it.path_id     = pick_path(plim);
    it.channel_id  = pick_chan(clim);
    it.path_any    = 1'($urandom);
    it.channel_any = 1'($urandom);
    it.tx_active   = 1'($urandom);
    it.rx_active   = 1'($urandom);
    return it;
  endfunction

  task automatic send_item(item_t it);
    int unsigned gap;
    gap = pick_gap(src_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.opcode;
    s_axis_tdata  <= {1'b0, it.rx_active, it.tx_active, it.channel_any, it.path_any,
                      it.channel_id, it.path_id, it.entry_valid, it.slot};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_transfer(it);
    if ($urandom_range(0, 49) == 0) src_quiet = !src_quiet;
  endtask

  // finds without a result still in flight may outlast the last result
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (SCAN_TAIL) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [CFG_DW-1:0] pbits, logic [CFG_DW-1:0] cbits);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_PATH_BITS;
    cfg_wdata_i <= pbits;
    @(posedge clk_i);
    board.set_reg(REG_PATH_BITS, pbits);
    cfg_idx_i   <= REG_CHAN_BITS;
    cfg_wdata_i <= cbits;
    @(posedge clk_i);
    board.set_reg(REG_CHAN_BITS, cbits);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      gap = pick_gap(sink_quiet);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.check_transfer(m_axis_tuser, m_axis_tdata[PATH_W-1:0],
                           m_axis_tdata[PATH_W+CHAN_W-1:PATH_W]);
      if ($urandom_range(0, 49) == 0) sink_quiet = !sink_quiet;
    end
  end

  initial begin
    int unsigned pb, cb, plim, clim;
    logic [CFG_DW-1:0] pval;
    board = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration, empty table
    send_item(make_find(1, 1, 0, 0, 1, 0));
    send_item(make_write(0, 1, 0, 32, 1, 0));
    send_item(make_find(1, 1, 0, 0, 1, 0));
    send_item(make_find(1, 1, 0, 0, 0, 1));
    send_item(make_find(0, 0, 0, 32, 1, 0));
    send_item(make_find(0, 0, 0, 32, 0, 1));
    send_item(make_find(0, 0, 0, 32, 0, 0));
    send_item(make_write(63, 1, 4095, 65535, 1, 1));
    send_item(make_find(0, 0, 4095, 65535, 1, 1));
    send_item(make_find(0, 1, 4095, 0, 1, 1));
    send_item(make_find(1, 0, 0, 65535, 1, 1));
    send_item(make_write(0, 0, 0, 32, 1, 0));
    send_item(make_find(0, 0, 0, 32, 1, 0));
    settle();

    // channel limit below the reserved range: only channel 32 is a candidate
    write_regs(5'd1, 5'd5);
    send_item(make_write(1, 1, 0, 32, 1, 0));
    send_item(make_write(2, 1, 1, 32, 1, 0));
    send_item(make_find(1, 1, 0, 0, 1, 0));
    send_item(make_find(1, 1, 0, 0, 0, 1));
    send_item(make_find(0, 1, 1, 0, 1, 0));
    send_item(make_find(1, 0, 0, 32, 1, 0));
    send_item(make_find(1, 1, 0, 0, 0, 0));
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      pval = CFG_DW'(phase_pbits[ph]);
      pval[CFG_DW-1] = 1'($urandom);
      write_regs(pval, CFG_DW'(phase_cbits[ph]));
      pb   = (phase_pbits[ph] > MAX_PATH_BITS_DEF) ? MAX_PATH_BITS_DEF : phase_pbits[ph];
      cb   = (phase_cbits[ph] > MAX_CHANNEL_BITS_DEF) ? MAX_CHANNEL_BITS_DEF
                                                       : phase_cbits[ph];
      plim = 1 << pb;
      clim = 1 << cb;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(random_item(plim, clim));
      end
      settle();
    end

    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/fcis_pkg.sv
rtl/fcis_table.sv
rtl/fcis_seq.sv
rtl/free_channel_id_search.sv
verif/free_channel_id_search_test.sv
